// ===== rtl/planar_odometry_integrator_defines.svh =====
// ----------------------------------------------------------------------------
// Planar odometry integrator assertion macros
// Shared property wrappers for the assertion checker.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define POI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/poi_pkg.sv =====
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Fixed-point constants, CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package poi_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
	localparam logic [31:0] RAD_TO_BAM = 32'd2670177;
	localparam logic [15:0] TIME_STEP_RESET = 16'd1311;

	typedef struct packed {
		logic done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} poi_sincos_t;

	// arctan(2^-i) in binary-angle units, 2^24 per turn
	function automatic logic [21:0] atan_bam(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0: r = 22'd2097152;
			5'd1: r = 22'd1238021;
			5'd2: r = 22'd654136;
			5'd3: r = 22'd332050;
			5'd4: r = 22'd166669;
			5'd5: r = 22'd83416;
			5'd6: r = 22'd41718;
			5'd7: r = 22'd20860;
			5'd8: r = 22'd10430;
			5'd9: r = 22'd5215;
			5'd10: r = 22'd2608;
			5'd11: r = 22'd1304;
			5'd12: r = 22'd652;
			5'd13: r = 22'd326;
			5'd14: r = 22'd163;
			5'd15: r = 22'd81;
			5'd16: r = 22'd41;
			5'd17: r = 22'd20;
			5'd18: r = 22'd10;
			5'd19: r = 22'd5;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/poi_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 25 x 32 multiply with a registered product.
// ----------------------------------------------------------------------------
module poi_mul (
	input  logic               clk,
	input  logic signed [24:0] a,
	input  logic signed [31:0] b,
	output logic signed [56:0] p
);

	logic signed [56:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 57'(a) * 57'(b);
	end

	assign p = p_q;

endmodule

// ===== rtl/poi_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative CORDIC sine/cosine
// One rotation step per cycle through a shared add/sub and barrel shift,
// quadrant folding and Q1.30 clamp at the end.
// ----------------------------------------------------------------------------
module poi_cordic import poi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] angle,
	output poi_sincos_t res
);

	logic signed [31:0] x_q, y_q, cos_q, sin_q;
	logic signed [24:0] z_q;
	logic [4:0]         iter_q;
	logic [1:0]         quad_q;
	logic               run_q, done_q;

	logic signed [31:0] dx, dy, x_n, y_n, xc, yc;
	logic signed [24:0] z_n, at;
	logic               last;

	function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > Q30_ONE) begin
			r = Q30_ONE;
		end else if (v < -Q30_ONE) begin
			r = -Q30_ONE;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_comb begin
		dx = y_q >>> iter_q;
		dy = x_q >>> iter_q;
		at = $signed({3'b000, atan_bam(iter_q)});
		if (!z_q[24]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
		xc = clamp_q30(x_n);
		yc = clamp_q30(y_n);
		last = (iter_q == 5'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + 5'd1;
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= $signed({3'b000, angle[21:0]});
			quad_q <= angle[23:22];
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (last) begin
				case (quad_q)
					2'd0: begin
						cos_q <= xc;
						sin_q <= yc;
					end
					2'd1: begin
						cos_q <= -yc;
						sin_q <= xc;
					end
					2'd2: begin
						cos_q <= -xc;
						sin_q <= -yc;
					end
					default: begin
						cos_q <= yc;
						sin_q <= -xc;
					end
				endcase
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule

// ===== rtl/planar_odometry_integrator.sv =====
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning x/y/heading integration of body-frame velocity samples.
// ----------------------------------------------------------------------------
// Input stream: one transfer per velocity sample (forward, lateral, yaw rate,
// Q8.16). Output stream: one transfer per sample with the new position
// (Q16.16, saturating), the 24-bit binary heading and the yaw quaternion
// z/w (Q1.15, sin/cos of half the heading).
// time_step (Q0.16 s) is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle; the block does not enforce this.
// Each sample runs a 20-step CORDIC on the old heading, multiply-accumulate
// steps on the shared 25x32 multiplier, an update state and a second
// 20-step CORDIC on the new half heading. The next input is taken in the
// cycle after the result is loaded, so a new sample is not accepted while
// the last one is still in progress.
// The finished result sits in an output register; if it is still held when
// the next result is ready, the sequencer waits until the receiver takes it.
// Reset clears position and heading to zero and time_step to 1311.
// ----------------------------------------------------------------------------
module planar_odometry_integrator import poi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,  // time_step
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,      // vel_forward, vel_lateral, yaw_rate
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata       // pos_x, pos_y, heading, quat_z, quat_w
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COR1 = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_COR2 = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;
	localparam logic [3:0] LAST_STEP = 4'd11;

	logic [2:0]  state_q;
	logic [3:0]  step_q;
	logic [15:0] time_step_q;
	logic        m_tvalid_q;
	logic [119:0] out_q;

	logic signed [23:0] vel_forward_q, vel_lateral_q, yaw_rate_q;
	logic signed [31:0] co_q, si_q, pos_x_q, pos_y_q;
	logic [23:0]        heading_q;
	logic [15:0]        quat_z_q, quat_w_q;
	logic signed [57:0] ax_q, ay_q;
	logic signed [63:0] dx_q, dy_q, dth_q;
	logic signed [40:0] t_q;

	logic               cor_start;
	logic [23:0]        cor_angle;
	poi_sincos_t        cor_res;
	logic signed [24:0] mul_a;
	logic signed [31:0] mul_b, ts_op, k_op;
	logic signed [56:0] mul_p;
	logic signed [57:0] p58, ax_rnd, ay_rnd;
	logic signed [63:0] p64, dx_rnd, dy_rnd, dth_rnd;
	logic signed [41:0] rx, ry;
	logic signed [31:0] dx_s, dy_s, pos_x_n, pos_y_n;
	logic signed [32:0] sum_x, sum_y;
	logic [23:0]        heading_n;
	logic               in_xfer, out_free;

	function automatic logic [15:0] to_q15(input logic signed [31:0] v);
		logic signed [32:0] r;
		r = ($signed({v[31], v}) + 33'sd16384) >>> 15;
		if (r > 33'sd32767) begin
			r = 33'sd32767;
		end else if (r < -33'sd32767) begin
			r = -33'sd32767;
		end
		return r[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// rounding and position/heading update
	always_comb begin
		p58     = {mul_p[56], mul_p};
		p64     = {{7{mul_p[56]}}, mul_p};
		ax_rnd  = ax_q + 58'sd8192;
		ay_rnd  = ay_q + 58'sd8192;
		rx      = ax_rnd[55:14];
		ry      = ay_rnd[55:14];
		dx_rnd  = dx_q + 64'sh80000000;
		dy_rnd  = dy_q + 64'sh80000000;
		dth_rnd = dth_q + 64'sh80000000;
		dx_s    = dx_rnd[63:32];
		dy_s    = dy_rnd[63:32];
		sum_x   = {pos_x_q[31], pos_x_q} + {dx_s[31], dx_s};
		sum_y   = {pos_y_q[31], pos_y_q} + {dy_s[31], dy_s};
		pos_x_n = sat32(sum_x);
		pos_y_n = sat32(sum_y);
		heading_n = heading_q + dth_rnd[55:32];
	end

	assign cor_start = in_xfer || (state_q == ST_UPD);
	assign cor_angle = (state_q == ST_UPD) ? {1'b0, heading_n[23:1]} : heading_q;

	poi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.res    (cor_res)
	);

	// multiplier operand schedule
	always_comb begin
		ts_op = $signed({16'b0, time_step_q});
		k_op  = $signed(RAD_TO_BAM);
		case (step_q)
			4'd0: begin
				mul_a = {vel_forward_q[23], vel_forward_q};
				mul_b = co_q;
			end
			4'd1: begin
				mul_a = {vel_lateral_q[23], vel_lateral_q};
				mul_b = si_q;
			end
			4'd2: begin
				mul_a = {vel_forward_q[23], vel_forward_q};
				mul_b = si_q;
			end
			4'd3: begin
				mul_a = {vel_lateral_q[23], vel_lateral_q};
				mul_b = co_q;
			end
			4'd4: begin
				mul_a = $signed({4'b0, rx[20:0]});
				mul_b = ts_op;
			end
			4'd5: begin
				mul_a = {{4{rx[41]}}, rx[41:21]};
				mul_b = ts_op;
			end
			4'd6: begin
				mul_a = $signed({4'b0, ry[20:0]});
				mul_b = ts_op;
			end
			4'd7: begin
				mul_a = {{4{ry[41]}}, ry[41:21]};
				mul_b = ts_op;
			end
			4'd8: begin
				mul_a = {yaw_rate_q[23], yaw_rate_q};
				mul_b = ts_op;
			end
			4'd9: begin
				mul_a = $signed({5'b0, mul_p[19:0]});
				mul_b = k_op;
			end
			4'd10: begin
				mul_a = {{4{t_q[40]}}, t_q[40:20]};
				mul_b = k_op;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	poi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			time_step_q <= TIME_STEP_RESET;
			m_tvalid_q  <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				time_step_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_COR1;
					end
				end
				ST_COR1: begin
					if (cor_res.done) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					pos_x_q   <= pos_x_n;
					pos_y_q   <= pos_y_n;
					heading_q <= heading_n;
					state_q   <= ST_COR2;
				end
				ST_COR2: begin
					if (cor_res.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vel_forward_q <= s_tdata[23:0];
			vel_lateral_q <= s_tdata[47:24];
			yaw_rate_q    <= s_tdata[71:48];
		end
		if (state_q == ST_COR1 && cor_res.done) begin
			co_q <= cor_res.cos_v;
			si_q <= cor_res.sin_v;
		end
		if (state_q == ST_COR2 && cor_res.done) begin
			quat_z_q <= to_q15(cor_res.sin_v);
			quat_w_q <= to_q15(cor_res.cos_v);
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= {quat_w_q, quat_z_q, heading_q, pos_y_q, pos_x_q};
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				4'd1: ax_q <= p58;
				4'd2: ax_q <= ax_q - p58;
				4'd3: ay_q <= p58;
				4'd4: ay_q <= ay_q + p58;
				4'd5: dx_q <= p64;
				4'd6: dx_q <= dx_q + (p64 <<< 21);
				4'd7: dy_q <= p64;
				4'd8: dy_q <= dy_q + (p64 <<< 21);
				4'd9: t_q <= mul_p[40:0];
				4'd10: dth_q <= p64;
				4'd11: dth_q <= dth_q + (p64 <<< 20);
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ===== rtl/poi_checker.sv =====
// ----------------------------------------------------------------------------
// Planar odometry integrator port checker
// Port-level properties on stream handshakes and result encoding.
// ----------------------------------------------------------------------------
`include "planar_odometry_integrator_defines.svh"

module poi_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	`POI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	`POI_ASSERT_NEXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready ##1 !s_tready, "input taken while busy")

	`POI_ASSERT_SAME(a_quat_range, m_tvalid, m_tdata[103:88] != 16'h8000 && m_tdata[119:104] != 16'h8000, "quaternion out of range")

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives velocity samples through the input stream under random stalls on
// both sides and checks every pose transfer against a cycle-free predictor
// of the integrator (CORDIC rotation, saturating position, wrapping heading,
// half-angle quaternion), across several time-step settings.
// ----------------------------------------------------------------------------
module testbench;
	import poi_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int VMAX = 8388607;
	localparam int VMIN = -8388608;
	localparam int HOLD_AT = 500;
	localparam int HOLD_LEN = 600;
	localparam longint CORDIC_K = 652032874;
	localparam longint UNIT_Q30 = 1073741824;
	localparam longint RAD_BAM = 2670177;
	localparam logic [15:0] STEP_DEFAULT = 16'd1311;

	// fields from the highest bit down
	typedef struct packed {
		logic signed [23:0] wz;
		logic signed [23:0] vl;
		logic signed [23:0] vf;
	} vel_t;

	typedef struct packed {
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic [23:0]        hd;
		logic signed [31:0] py;
		logic signed [31:0] px;
	} pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [15:0]  cfg_wr_data = 16'd0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = 72'd0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;

	planar_odometry_integrator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #2 clk = ~clk;

	int atan_units [20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

	// predictor state
	logic signed [31:0] px_m = 32'sd0;
	logic signed [31:0] py_m = 32'sd0;
	logic [23:0]        head_m = 24'd0;
	logic [15:0]        step_m = STEP_DEFAULT;

	vel_t  pending_samples [$];
	pose_t expected_poses [$];
	int    errors = 0;
	int    sent = 0;
	int    rx_count = 0;
	int    cycles = 0;
	int    tx_gap = 0;
	int    rx_gap = 0;
	int    hold_left = 0;
	bit    hold_done = 1'b0;
	bit    calm = 1'b0;
	logic  in_taken = 1'b0;
	logic  out_taken = 1'b0;

	function automatic longint round_shr(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
		input longint d);
		longint s;
		s = clamp(longint'(a) + d, -64'sd2147483648, 64'sd2147483647);
		return s[31:0];
	endfunction

	function automatic logic signed [15:0] to_q15(input longint v);
		longint r;
		r = clamp(round_shr(v, 15), -32767, 32767);
		return r[15:0];
	endfunction

	task automatic cordic_sincos(input logic [23:0] ang, output longint co, output longint si);
		longint x, y, z, tx;
		x = CORDIC_K;
		y = 0;
		z = longint'(ang[21:0]);
		for (int i = 0; i < 20; i++) begin
			tx = x;
			if (z >= 0) begin
				x = x - (y >>> i);
				y = y + (tx >>> i);
				z = z - atan_units[i];
			end else begin
				x = x + (y >>> i);
				y = y - (tx >>> i);
				z = z + atan_units[i];
			end
		end
		x = clamp(x, -UNIT_Q30, UNIT_Q30);
		y = clamp(y, -UNIT_Q30, UNIT_Q30);
		case (ang[23:22])
			2'd0: begin co = x;  si = y;  end
			2'd1: begin co = -y; si = x;  end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	task automatic integrate_sample(input vel_t v, output pose_t p);
		longint vf, vl, wz, co, si, rx, ry, dth;
		vf = longint'($signed(v.vf));
		vl = longint'($signed(v.vl));
		wz = longint'($signed(v.wz));
		cordic_sincos(head_m, co, si);
		rx = round_shr(vf * co - vl * si, 14);
		ry = round_shr(vf * si + vl * co, 14);
		px_m = sat_add32(px_m, round_shr(rx * longint'(step_m), 32));
		py_m = sat_add32(py_m, round_shr(ry * longint'(step_m), 32));
		dth = round_shr(wz * longint'(step_m) * RAD_BAM, 32);
		head_m = head_m + dth[23:0];
		cordic_sincos({1'b0, head_m[23:1]}, co, si);
		p.px = px_m;
		p.py = py_m;
		p.hd = head_m;
		p.qz = to_q15(si);
		p.qw = to_q15(co);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [23:0] rand_field();
		int r, q;
		r = $urandom_range(0, 9);
		if (r == 0) q = VMAX;
		else if (r == 1) q = VMIN;
		else if (r == 2) q = 0;
		else if (r == 3) q = -1;
		else if (r == 4) q = int'($urandom_range(0, 2000)) - 1000;
		else q = int'($urandom);
		return q[23:0];
	endfunction

	function automatic logic [23:0] vel_from_real(input real r);
		int q;
		if (r > 8388607.0) q = VMAX;
		else if (r < -8388608.0) q = VMIN;
		else q = int'(r);
		return q[23:0];
	endfunction

	task automatic add_sample(input int f, input int l, input int w);
		vel_t v;
		v.vf = f[23:0];
		v.vl = l[23:0];
		v.wz = w[23:0];
		pending_samples.push_back(v);
	endtask

	task automatic add_random(input int n);
		vel_t v;
		for (int k = 0; k < n; k++) begin
			v.vf = rand_field();
			v.vl = rand_field();
			v.wz = rand_field();
			pending_samples.push_back(v);
		end
	endtask

	// steer a straight run in world coordinates from the current heading
	task automatic add_drift(input int n, input real wx, input real wy);
		real ang, c, s, jf, jl;
		vel_t v;
		int w;
		ang = 6.283185307179586 * head_m / 16777216.0;
		c = $cos(ang);
		s = $sin(ang);
		for (int k = 0; k < n; k++) begin
			jf = int'($urandom_range(0, 4000)) - 2000;
			jl = int'($urandom_range(0, 4000)) - 2000;
			w = int'($urandom_range(0, 100)) - 50;
			v.vf = vel_from_real(wx * c + wy * s + jf);
			v.vl = vel_from_real(-wx * s + wy * c + jl);
			v.wz = w[23:0];
			pending_samples.push_back(v);
		end
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_step(input logic [15:0] v);
		wait_drained();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		step_m = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sample transfers in, pose transfers out
	always @(posedge clk) begin
		pose_t want, got;
		cycles <= cycles + 1;
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = pose_t'(m_tdata);
			rx_count++;
			if (expected_poses.size() == 0) begin
				$display("%0t unexpected pose: x=%0d y=%0d heading=%0d", $time,
					got.px, got.py, got.hd);
				errors++;
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", want.px, got.px);
				check_field("pos_y", want.py, got.py);
				check_field("heading", want.hd, got.hd);
				check_field("quat_z", want.qz, got.qz);
				check_field("quat_w", want.qw, got.qw);
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			integrate_sample(vel_t'(s_tdata), want);
			expected_poses.push_back(want);
			sent++;
		end
	end

	always @(posedge clk) begin
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t timeout: %0d poses still expected", $time, expected_poses.size());
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		vel_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			s_tvalid <= 1'b1;
		end else if (tx_gap > 0) begin
			tx_gap = tx_gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_samples.size() > 0) begin
			nxt = pending_samples.pop_front();
			s_tdata <= nxt;
			s_tvalid <= 1'b1;
			tx_gap = calm ? 0 : pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		int g;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!hold_done && rx_count >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap = rx_gap - 1;
				m_tready <= 1'b0;
			end else if (out_taken && !calm) begin
				g = pick_gap();
				if (g > 0) begin
					rx_gap = g - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset time step, field extremes
		add_sample(0, 0, 0);
		add_sample(VMAX, 0, 0);
		add_sample(VMIN, 0, 0);
		add_sample(0, VMAX, 0);
		add_sample(0, VMIN, 0);
		add_sample(-1, -1, -1);
		add_sample(0, 0, VMAX);
		add_sample(VMAX, VMAX, VMAX);
		add_sample(VMIN, VMIN, VMIN);
		add_sample(1, 1, 1);

		// zero step: nothing moves
		write_step(16'd0);
		add_sample(VMAX, VMIN, VMAX);
		add_sample(VMIN, VMAX, VMIN);

		// full step: large turns, heading wraps both ways
		write_step(16'hFFFF);
		add_sample(0, 0, VMAX);
		add_sample(0, 0, VMAX);
		add_sample(0, 0, VMIN);
		add_sample(VMAX, VMAX, 0);
		add_sample(VMIN, VMAX, 0);
		add_sample(VMAX, VMIN, VMIN);
		add_sample(0, 0, 1);

		write_step(16'd1);
		add_sample(VMAX, VMAX, VMAX);
		add_sample(VMIN, VMIN, VMIN);
		add_sample(0, 0, -1);

		// drive into negative saturation on both axes, then across to +x
		write_step(16'hFFFF);
		calm = 1'b1;
		add_drift(400, -5800000.0, -5800000.0);
		wait_drained();
		calm = 1'b0;
		add_drift(540, 8300000.0, -500000.0);

		write_step(16'($urandom_range(2, 65534)));
		add_random(250);
		write_step(16'hFFFF);
		add_random(100);
		write_step(STEP_DEFAULT);
		calm = 1'b1;
		add_random(30);
		wait_drained();
		calm = 1'b0;
		add_random(40);

		wait_drained();
		repeat (80) @(posedge clk);
		$display("summary: %0d samples sent, %0d poses checked", sent, rx_count);
		$display("summary: steps 0/1/1311/max/random, x-y saturation, heading wrap, stalls");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/poi_pkg.sv
rtl/poi_mul.sv
rtl/poi_cordic.sv
rtl/planar_odometry_integrator.sv
rtl/poi_checker.sv
tb/sv/testbench.sv
